// ===== sv/multi_channel_byte_ring_fifo_core_defines.svh =====
// Assertion helpers shared by the RTL files.
`ifndef MULTI_CHANNEL_BYTE_RING_FIFO_CORE_DEFINES_SVH
`define MULTI_CHANNEL_BYTE_RING_FIFO_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MCBRF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled during reset.
`define MCBRF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== sv/mcbrf_pkg.sv =====
package mcbrf_pkg;

  // Opcodes on the input tuser
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_STATUS = 2'd3;

  // Longest read burst
  localparam logic [6:0] MAX_BURST = 7'd64;

  // Configuration port
  localparam int NUM_CFG = 3;
  localparam int CFG_AW  = 4;

  // Command and result queues
  localparam int QUEUE_LOG2  = 2;
  localparam int QUEUE_DEPTH = 2 ** QUEUE_LOG2;

  // Stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_CLEAR,
    CMD_STATUS,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [1:0] channel;
    logic [7:0] data;
    logic [6:0] count;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       byte_valid;
    logic       last;
    logic       accepted;
    logic [8:0] fill_level;
    logic [8:0] free_space;
  } res_t;

  typedef struct packed {
    logic       wr;
    logic [1:0] index;
    logic [8:0] value;
  } cfg_wr_t;

endpackage

// ===== sv/mcbrf_queue.sv =====
module mcbrf_queue #(
  parameter int WIDTH = 8,
  parameter int LOG2  = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             valid,
  output logic             full,
  output logic [LOG2:0]    count
);

  logic [WIDTH-1:0] slots [2**LOG2];
  logic [LOG2-1:0]  wr_ptr;
  logic [LOG2-1:0]  rd_ptr;
  logic             push_ok;
  logic             pop_ok;

  assign valid   = (count != '0);
  assign full    = (count == (LOG2+1)'(2**LOG2));
  assign push_ok = push && !full;
  assign pop_ok  = pop && valid;
  assign head    = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + LOG2'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + LOG2'(1);
      end
      count <= count + (LOG2+1)'(push_ok) - (LOG2+1)'(pop_ok);
    end
  end

endmodule

// ===== sv/mcbrf_front.sv =====
module mcbrf_front #(
  parameter int CHANNELS = 3
) (
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mcbrf_pkg::IN_TDATA_W-1:0]    s_tdata,  // data_in[7:0], read_count[14:8]
  input  logic [mcbrf_pkg::IN_TUSER_W-1:0]    s_tuser,  // op[1:0], channel[3:2]
  input  logic                                q_full,
  output logic                                push,
  output mcbrf_pkg::cmd_t                     cmd
);

  logic [1:0] op;
  logic [1:0] chan;
  logic [6:0] want;
  logic       chan_ok;

  assign op      = s_tuser[1:0];
  assign chan    = s_tuser[3:2];
  assign want    = s_tdata[14:8];
  assign chan_ok = (32'(chan) < CHANNELS);

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // classify the transfer into a command
  always_comb begin
    cmd.channel = chan;
    cmd.data    = s_tdata[7:0];
    cmd.count   = (want > mcbrf_pkg::MAX_BURST) ? mcbrf_pkg::MAX_BURST : want;
    unique case (op)
      mcbrf_pkg::OP_WRITE:  cmd.kind = mcbrf_pkg::CMD_WRITE;
      mcbrf_pkg::OP_READ:   cmd.kind = mcbrf_pkg::CMD_READ;
      mcbrf_pkg::OP_CLEAR:  cmd.kind = mcbrf_pkg::CMD_CLEAR;
      mcbrf_pkg::OP_STATUS: cmd.kind = mcbrf_pkg::CMD_STATUS;
      default:              cmd.kind = mcbrf_pkg::CMD_STATUS;
    endcase
    // out-of-range channel: ignored, parked on channel zero
    if (!chan_ok) begin
      cmd.kind    = mcbrf_pkg::CMD_BAD;
      cmd.channel = 2'd0;
    end
  end

endmodule

// ===== sv/mcbrf_engine.sv =====
`include "multi_channel_byte_ring_fifo_core_defines.svh"

module mcbrf_engine #(
  parameter int CHANNELS = 3,
  parameter int DEPTH    = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  input  mcbrf_pkg::cmd_t                  cmd,
  output logic                             cmd_pop,
  input  logic [mcbrf_pkg::QUEUE_LOG2:0]   res_count,
  output logic                             res_push,
  output mcbrf_pkg::res_t                  res,
  input  mcbrf_pkg::cfg_wr_t               cfg,
  input  logic [1:0]                       cfg_rindex,
  output logic [$clog2(DEPTH+1)-1:0]       cfg_rdata
);

  localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW  = $clog2(DEPTH);
  localparam int SW  = $clog2(DEPTH + 1);
  localparam int AW  = $clog2(CHANNELS * DEPTH);
  localparam int QW  = mcbrf_pkg::QUEUE_LOG2 + 1;

  // per-channel state
  logic [SW-1:0] sizes [CHANNELS];
  logic [SW-1:0] fills [CHANNELS];
  logic [IW-1:0] widx  [CHANNELS];
  logic [IW-1:0] ridx  [CHANNELS];

  // shared byte store, one region of DEPTH bytes per channel
  logic [7:0]    store [CHANNELS * DEPTH];
  logic [7:0]    rd_data;

  // burst tracking
  logic          active;
  logic [6:0]    rem;

  // result stage
  logic            e2_valid;
  logic            e2_byte;
  mcbrf_pkg::res_t e2_res;

  logic [CIW-1:0]  ch_i;
  logic [SW-1:0]   size_c;
  logic [SW-1:0]   fill_c;
  logic [IW-1:0]   wi_c;
  logic [IW-1:0]   ri_c;
  logic [IW-1:0]   wi_next;
  logic [IW-1:0]   ri_next;
  logic [AW-1:0]   base;
  logic [6:0]      rem_cur;
  logic            room;
  logic            go;
  logic            has_room;
  logic            rd_empty;
  logic            pop_last;
  logic            mem_we;
  logic            do_pop;
  logic [SW-1:0]   fill_new;
  mcbrf_pkg::res_t res_n;
  logic [CIW-1:0]  cfg_ci;
  logic            cfg_ok;
  logic            rd_ok;
  logic [SW-1:0]   cfg_size;

  // head command's channel view
  assign ch_i    = CIW'(cmd.channel);
  assign size_c  = sizes[ch_i];
  assign fill_c  = fills[ch_i];
  assign wi_c    = widx[ch_i];
  assign ri_c    = ridx[ch_i];
  assign base    = AW'(32'(ch_i) * DEPTH);
  assign wi_next = ((SW'(wi_c) + SW'(1)) >= size_c) ? '0 : wi_c + IW'(1);
  assign ri_next = ((SW'(ri_c) + SW'(1)) >= size_c) ? '0 : ri_c + IW'(1);

  // one result slot must be free for every result in flight
  assign room    = (res_count + QW'(e2_valid)) < QW'(mcbrf_pkg::QUEUE_DEPTH);
  assign go      = cmd_valid && room;

  assign rem_cur  = active ? rem : cmd.count;
  assign has_room = (fill_c < size_c);
  assign rd_empty = (rem_cur == 7'd0) || (fill_c == '0);
  assign pop_last = (rem_cur == 7'd1) || (fill_c == SW'(1));

  // execute the head command
  always_comb begin
    cmd_pop  = 1'b0;
    mem_we   = 1'b0;
    do_pop   = 1'b0;
    fill_new = fill_c;
    res_n    = '0;
    res_n.last = 1'b1;
    if (go) begin
      unique case (cmd.kind)
        mcbrf_pkg::CMD_WRITE: begin
          cmd_pop = 1'b1;
          if (has_room) begin
            mem_we         = 1'b1;
            fill_new       = fill_c + SW'(1);
            res_n.accepted = 1'b1;
          end
        end
        mcbrf_pkg::CMD_READ: begin
          if (rd_empty) begin
            cmd_pop = 1'b1;
          end else begin
            do_pop           = 1'b1;
            fill_new         = fill_c - SW'(1);
            res_n.byte_valid = 1'b1;
            res_n.last       = pop_last;
            cmd_pop          = pop_last;
          end
        end
        mcbrf_pkg::CMD_CLEAR: begin
          cmd_pop  = 1'b1;
          fill_new = '0;
        end
        mcbrf_pkg::CMD_STATUS: begin
          cmd_pop = 1'b1;
        end
        mcbrf_pkg::CMD_BAD: begin
          cmd_pop = 1'b1;
        end
        default: begin
          cmd_pop = 1'b1;
        end
      endcase
    end
    if (cmd.kind != mcbrf_pkg::CMD_BAD) begin
      res_n.fill_level = 9'(fill_new);
      res_n.free_space = 9'(size_c - fill_new);
    end
  end

  // byte store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[base + AW'(wi_c)] <= cmd.data;
    end
    rd_data <= store[base + AW'(ri_c)];
  end

  // size register write: zero means one, above DEPTH means DEPTH
  assign cfg_ci   = CIW'(cfg.index);
  assign cfg_ok   = (32'(cfg.index) < mcbrf_pkg::NUM_CFG) && (32'(cfg.index) < CHANNELS);
  assign cfg_size = (cfg.value == '0) ? SW'(1) :
                    ((32'(cfg.value) > DEPTH) ? SW'(DEPTH) : SW'(cfg.value));

  // size register read
  assign rd_ok     = (32'(cfg_rindex) < mcbrf_pkg::NUM_CFG) && (32'(cfg_rindex) < CHANNELS);
  assign cfg_rdata = rd_ok ? sizes[CIW'(cfg_rindex)] : '0;

  // channel state, burst tracking and result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sizes[c] <= SW'(DEPTH);
        fills[c] <= '0;
        widx[c]  <= '0;
        ridx[c]  <= '0;
      end
      active   <= 1'b0;
      rem      <= '0;
      e2_valid <= 1'b0;
    end else begin
      e2_valid <= go;
      if (go) begin
        fills[ch_i] <= fill_new;
        if (mem_we) begin
          widx[ch_i] <= wi_next;
        end
        if (do_pop) begin
          ridx[ch_i] <= ri_next;
        end
        if (cmd.kind == mcbrf_pkg::CMD_CLEAR) begin
          widx[ch_i] <= '0;
          ridx[ch_i] <= '0;
        end
        if (cmd.kind == mcbrf_pkg::CMD_READ) begin
          active <= do_pop && !pop_last;
          rem    <= rem_cur - 7'd1;
        end
      end
      if (cfg.wr && cfg_ok) begin
        sizes[cfg_ci] <= cfg_size;
        fills[cfg_ci] <= '0;
        widx[cfg_ci]  <= '0;
        ridx[cfg_ci]  <= '0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    e2_res  <= res_n;
    e2_byte <= do_pop;
  end

  always_comb begin
    res          = e2_res;
    res.data_out = e2_byte ? rd_data : 8'h00;
  end

  assign res_push = e2_valid;

  // checks
  `MCBRF_ASSERT_IMP(a_fill_bound, clk, rst, cmd_valid && (cmd.kind != mcbrf_pkg::CMD_BAD), fill_c <= size_c)
  `MCBRF_ASSERT_IMP(a_burst_head, clk, rst, active, cmd_valid && (cmd.kind == mcbrf_pkg::CMD_READ))
  `MCBRF_ASSERT_IMP(a_res_room, clk, rst, e2_valid, res_count < QW'(mcbrf_pkg::QUEUE_DEPTH))
  `MCBRF_ASSERT_NXT(a_burst_end, clk, rst, do_pop && pop_last, e2_valid && e2_res.last && e2_byte)

endmodule

// ===== sv/multi_channel_byte_ring_fifo_core.sv =====
// Byte FIFO channels sharing one store. Each command on the slave stream (write a
// byte, read a burst of up to 64 bytes, clear a channel, query status) enters a
// four-entry command queue; while the result queue has room, the engine takes one
// command or one burst byte per cycle, so writes, clears and status queries run at
// one per cycle and a read burst of n bytes gives n results. That one-byte-per-cycle
// figure comes from the single read port of the shared store, whose registered read
// feeds a four-entry result queue. Every result on an in-range channel carries the
// channel's fill and free counts. Channel sizes are written over the APB port (byte
// address 4*i for channel i), which also empties that channel; write them only while
// no commands are outstanding. No memory clear after reset.
`include "multi_channel_byte_ring_fifo_core_defines.svh"

module multi_channel_byte_ring_fifo_core #(
  parameter int CHANNELS = 3,
  parameter int DEPTH    = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // command stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [mcbrf_pkg::IN_TDATA_W-1:0]     s_tdata,  // data_in[7:0], read_count[14:8]
  input  logic [mcbrf_pkg::IN_TUSER_W-1:0]     s_tuser,  // op[1:0], channel[3:2]
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [mcbrf_pkg::OUT_TDATA_W-1:0]    m_tdata,  // data_out[7:0], fill_level[16:8],
                                                         // free_space[25:17]
  output logic [mcbrf_pkg::OUT_TUSER_W-1:0]    m_tuser,  // byte_valid[0], accepted[1]
  output logic                                 m_tlast,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mcbrf_pkg::CFG_AW-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = $bits(mcbrf_pkg::cmd_t);
  localparam int RW = $bits(mcbrf_pkg::res_t);

  logic                                cq_push;
  mcbrf_pkg::cmd_t                     cq_in;
  logic [CW-1:0]                       cq_head;
  logic                                cq_valid;
  logic                                cq_full;
  logic [mcbrf_pkg::QUEUE_LOG2:0]      cq_count;
  logic                                cq_pop;
  mcbrf_pkg::cmd_t                     cmd;

  logic                                rq_push;
  mcbrf_pkg::res_t                     rq_in;
  logic [RW-1:0]                       rq_head;
  logic                                rq_full;
  logic [mcbrf_pkg::QUEUE_LOG2:0]      rq_count;
  mcbrf_pkg::res_t                     res;

  mcbrf_pkg::cfg_wr_t                  cfg;
  logic [SW-1:0]                       cfg_rdata;

  // register access
  assign cfg.wr    = psel && penable && pwrite;
  assign cfg.index = paddr[3:2];
  assign cfg.value = pwdata[8:0];
  assign pready    = 1'b1;
  assign prdata    = 32'(cfg_rdata);

  mcbrf_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (cq_full),
    .push     (cq_push),
    .cmd      (cq_in)
  );

  mcbrf_queue #(
    .WIDTH (CW),
    .LOG2  (mcbrf_pkg::QUEUE_LOG2)
  ) u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cq_push),
    .push_data (cq_in),
    .pop       (cq_pop),
    .head      (cq_head),
    .valid     (cq_valid),
    .full      (cq_full),
    .count     (cq_count)
  );

  assign cmd = mcbrf_pkg::cmd_t'(cq_head);

  mcbrf_engine #(
    .CHANNELS (CHANNELS),
    .DEPTH    (DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cq_valid),
    .cmd        (cmd),
    .cmd_pop    (cq_pop),
    .res_count  (rq_count),
    .res_push   (rq_push),
    .res        (rq_in),
    .cfg        (cfg),
    .cfg_rindex (paddr[3:2]),
    .cfg_rdata  (cfg_rdata)
  );

  mcbrf_queue #(
    .WIDTH (RW),
    .LOG2  (mcbrf_pkg::QUEUE_LOG2)
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rq_push),
    .push_data (rq_in),
    .pop       (m_tready),
    .head      (rq_head),
    .valid     (m_tvalid),
    .full      (rq_full),
    .count     (rq_count)
  );

  // result transfer
  assign res     = mcbrf_pkg::res_t'(rq_head);
  assign m_tdata = {6'd0, res.free_space, res.fill_level, res.data_out};
  assign m_tuser = {res.accepted, res.byte_valid};
  assign m_tlast = res.last;

  // checks: neither queue is ever pushed while full
  `MCBRF_ASSERT_IMP(a_res_no_drop, clk, rst, rq_push, !rq_full)
  `MCBRF_ASSERT_IMP(a_cmd_no_drop, clk, rst, cq_push, cq_count < (mcbrf_pkg::QUEUE_LOG2+1)'(mcbrf_pkg::QUEUE_DEPTH))

endmodule

// ===== bench/ring_fifo_checker.sv =====
module ring_fifo_checker
  import mcbrf_pkg::*;
#(
  parameter int CHANNELS = 3,
  parameter int DEPTH    = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // data_in[7:0], read_count[14:8]
  input  logic [IN_TUSER_W-1:0]  s_tuser,   // op[1:0], channel[3:2]
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // data_out[7:0], fill_level[16:8], free_space[25:17]
  input  logic [OUT_TUSER_W-1:0] m_tuser,   // byte_valid[0], accepted[1]
  input  logic                   m_tlast,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [31:0]            pwdata,
  input  logic                   pready,
  output int                     mismatches,
  output int                     outstanding
);

  localparam int IW = $clog2(DEPTH);

  // shadow copy of the channels
  logic [7:0]    shadow_bytes [CHANNELS][DEPTH];
  logic [IW-1:0] push_ptr [CHANNELS];
  logic [IW-1:0] pop_ptr [CHANNELS];
  logic [8:0]    held [CHANNELS];
  logic [8:0]    capacity [CHANNELS];

  // results still owed by the block, oldest first
  res_t due_results [$];

  function automatic logic [IW-1:0] wrap_next(logic [IW-1:0] idx, logic [8:0] cap);
    return (int'(idx) + 1 >= int'(cap)) ? '0 : idx + 1'b1;
  endfunction

  function automatic res_t make_result(logic [7:0] d, logic v, logic l, logic a,
                                       logic [8:0] f, logic [8:0] s);
    res_t r;
    r.data_out   = d;
    r.byte_valid = v;
    r.last       = l;
    r.accepted   = a;
    r.fill_level = f;
    r.free_space = s;
    return r;
  endfunction

  function automatic void empty_channel(int c);
    push_ptr[c] = '0;
    pop_ptr[c]  = '0;
    held[c]     = '0;
  endfunction

  // size register write: clamp to 1..DEPTH and start the channel over
  function automatic void load_capacity(logic [1:0] idx, logic [8:0] val);
    if (idx >= CHANNELS) return;
    if (val == 0) capacity[idx] = 9'd1;
    else if (val > DEPTH) capacity[idx] = 9'(DEPTH);
    else capacity[idx] = val;
    empty_channel(idx);
  endfunction

  // one command in, its results queued
  function automatic void run_fifo_op(logic [1:0] op, logic [1:0] ch, logic [7:0] din,
                                      logic [6:0] cnt);
    logic [8:0] cap;
    logic [6:0] burst;
    logic       stored;
    int         n;
    if (ch >= CHANNELS) begin
      due_results.push_back(make_result(8'd0, 1'b0, 1'b1, 1'b0, 9'd0, 9'd0));
      return;
    end
    cap = capacity[ch];
    case (op)
      OP_WRITE: begin
        stored = 1'b0;
        if (held[ch] < cap) begin
          shadow_bytes[ch][push_ptr[ch]] = din;
          push_ptr[ch] = wrap_next(push_ptr[ch], cap);
          held[ch]++;
          stored = 1'b1;
        end
        due_results.push_back(make_result(8'd0, 1'b0, 1'b1, stored, held[ch],
                                          cap - held[ch]));
      end
      OP_READ: begin
        burst = (cnt > MAX_BURST) ? MAX_BURST : cnt;
        n = (burst < held[ch]) ? burst : held[ch];
        if (n == 0)
          due_results.push_back(make_result(8'd0, 1'b0, 1'b1, 1'b0, held[ch],
                                            cap - held[ch]));
        for (int k = 0; k < n; k++) begin
          held[ch]--;
          due_results.push_back(make_result(shadow_bytes[ch][pop_ptr[ch]], 1'b1,
                                            k + 1 == n, 1'b0, held[ch], cap - held[ch]));
          pop_ptr[ch] = wrap_next(pop_ptr[ch], cap);
        end
      end
      default: begin
        if (op == OP_CLEAR) empty_channel(ch);
        due_results.push_back(make_result(8'd0, 1'b0, 1'b1, 1'b0, held[ch],
                                          cap - held[ch]));
      end
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      due_results.delete();
      for (int c = 0; c < CHANNELS; c++) begin
        empty_channel(c);
        capacity[c] = 9'(DEPTH);
      end
    end else begin
      // result transfer against the oldest expectation
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: data_out %0d last %0d", m_tdata[7:0], m_tlast);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("data_out", want.data_out, m_tdata[7:0]);
          check_field("byte_valid", want.byte_valid, m_tuser[0]);
          check_field("last", want.last, m_tlast);
          check_field("accepted", want.accepted, m_tuser[1]);
          check_field("fill_level", want.fill_level, m_tdata[16:8]);
          check_field("free_space", want.free_space, m_tdata[25:17]);
        end
      end
      if (psel && penable && pwrite && pready)
        load_capacity(paddr[3:2], pwdata[8:0]);
      if (s_tvalid && s_tready)
        run_fifo_op(s_tuser[1:0], s_tuser[3:2], s_tdata[7:0], s_tdata[14:8]);
    end
    outstanding <= due_results.size();
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  import mcbrf_pkg::*;

  localparam int CHANNELS    = 3;
  localparam int DEPTH       = 256;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 20;
  localparam int CYCLE_LIMIT = 200000;

  // size register addresses
  localparam logic [CFG_AW-1:0] ADDR_SIZE_CH0 = 4'd0;
  localparam logic [CFG_AW-1:0] ADDR_SIZE_CH1 = 4'd4;
  localparam logic [CFG_AW-1:0] ADDR_SIZE_CH2 = 4'd8;
  localparam logic [CFG_AW-1:0] ADDR_UNMAPPED = 4'd12;

  // channel number past the last channel
  localparam logic [1:0] CH_BAD = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // data_in[7:0], read_count[14:8]
  logic [IN_TUSER_W-1:0]  s_tuser = '0;   // op[1:0], channel[3:2]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // data_out[7:0], fill_level[16:8], free_space[25:17]
  logic [OUT_TUSER_W-1:0] m_tuser;        // byte_valid[0], accepted[1]
  logic                   m_tlast;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_AW-1:0]      paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  bit calm = 1'b0;       // no idling on either side
  bit long_hold = 1'b0;  // asks the sink for one long stall

  always #1 clk = ~clk;

  multi_channel_byte_ring_fifo_core #(.CHANNELS(CHANNELS), .DEPTH(DEPTH)) u_top (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ring_fifo_checker #(.CHANNELS(CHANNELS), .DEPTH(DEPTH)) u_checker (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .outstanding
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL multi_channel_byte_ring_fifo_core");
      $finish;
    end
  end

  // result sink: random stall bursts, quiet stretches, one long stall on request
  initial begin : sink
    bit held_off;
    int quiet;
    held_off = 1'b0;
    quiet = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold && !held_off) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && quiet == 0 && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        if ($urandom_range(0, 3) == 0) quiet = $urandom_range(20, 60);
      end else begin
        m_tready <= 1'b1;
        if (quiet > 0) quiet--;
        @(posedge clk);
      end
    end
  end

  // one command transfer, with an occasional gap in front
  task automatic send_cmd(input logic [1:0] op, input logic [1:0] ch,
                          input logic [7:0] din, input logic [6:0] cnt);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, cnt, din};
    s_tuser  <= {ch, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending and wait until every owed result is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_sizes(input logic [31:0] s0, input logic [31:0] s1,
                           input logic [31:0] s2);
    apb_write(ADDR_SIZE_CH0, s0);
    apb_write(ADDR_SIZE_CH1, s1);
    apb_write(ADDR_SIZE_CH2, s2);
  endtask

  // mostly valid channels, short reads, now and then a wide read count
  task automatic random_cmd(input int write_pct, input int max_cnt);
    int         pick;
    logic [1:0] op;
    logic [1:0] ch;
    logic [6:0] cnt;
    pick = $urandom_range(0, 99);
    if (pick < write_pct) op = OP_WRITE;
    else if (pick < write_pct + (100 - write_pct) * 6 / 10) op = OP_READ;
    else if (pick < write_pct + (100 - write_pct) * 3 / 4) op = OP_CLEAR;
    else op = OP_STATUS;
    ch = ($urandom_range(0, 24) == 0) ? CH_BAD : 2'($urandom_range(0, CHANNELS - 1));
    if ($urandom_range(0, 9) == 0) cnt = 7'($urandom_range(0, 127));
    else cnt = 7'($urandom_range(1, max_cnt));
    send_cmd(op, ch, 8'($urandom_range(0, 255)), cnt);
  endtask

  task automatic random_phase(input int items, input int write_pct, input int max_cnt);
    repeat (items) random_cmd(write_pct, max_cnt);
    wait_drained();
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: tiny channels, size zero clamps to one
    set_sizes(32'd3, 32'd1, 32'd0);
    send_cmd(OP_READ,   2'd0, 8'h00, 7'd5);     // empty channel
    send_cmd(OP_WRITE,  2'd0, 8'h00, 7'd0);
    send_cmd(OP_WRITE,  2'd0, 8'hFF, 7'd0);
    send_cmd(OP_WRITE,  2'd0, 8'hA5, 7'd0);
    send_cmd(OP_WRITE,  2'd0, 8'h5A, 7'd0);     // full, dropped
    send_cmd(OP_STATUS, 2'd0, 8'h00, 7'd0);
    send_cmd(OP_READ,   2'd0, 8'h00, 7'd0);     // zero count
    send_cmd(OP_READ,   2'd0, 8'h00, 7'd127);   // saturates, drains three
    send_cmd(OP_WRITE,  2'd0, 8'h3C, 7'd0);     // write pointer wraps
    send_cmd(OP_WRITE,  2'd0, 8'hC3, 7'd0);
    send_cmd(OP_READ,   2'd0, 8'h00, 7'd1);
    send_cmd(OP_WRITE,  2'd1, 8'hFF, 7'd0);
    send_cmd(OP_WRITE,  2'd1, 8'h01, 7'd0);     // one-byte channel full
    send_cmd(OP_READ,   2'd1, 8'h00, 7'd64);
    send_cmd(OP_WRITE,  2'd2, 8'h80, 7'd0);
    send_cmd(OP_CLEAR,  2'd2, 8'h00, 7'd0);
    send_cmd(OP_STATUS, 2'd2, 8'h00, 7'd0);
    send_cmd(OP_READ,   2'd2, 8'h00, 7'd64);
    send_cmd(OP_WRITE,  CH_BAD, 8'hFF, 7'd127); // bad channel, all ops
    send_cmd(OP_READ,   CH_BAD, 8'hFF, 7'd127);
    send_cmd(OP_CLEAR,  CH_BAD, 8'hFF, 7'd127);
    send_cmd(OP_STATUS, CH_BAD, 8'hFF, 7'd127);
    send_cmd(OP_WRITE,  2'd0, 8'h77, 7'd0);     // left behind for the resize
    wait_drained();

    // small rings, frequent overflow; resize drops leftover bytes
    apb_write(ADDR_UNMAPPED, 32'd5);
    set_sizes(32'd2, 32'd3, 32'd7);
    random_phase(40, 50, 6);

    // full-depth ring (oversize clamps), one-byte ring; long sink stall
    set_sizes(32'h1FF, 32'd1, 32'd16);
    long_hold = 1'b1;
    random_phase(40, 60, 20);

    // random small sizes with stray upper data bits
    set_sizes({23'($urandom), 9'($urandom_range(1, 12))},
              32'($urandom_range(1, 12)), 32'($urandom_range(1, 12)));
    random_phase(40, 55, 10);

    // closing stretch without idling
    calm = 1'b1;
    set_sizes(32'd0, 32'd256, 32'($urandom_range(1, 40)));
    random_phase(40, 55, 64);

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS multi_channel_byte_ring_fifo_core");
    end else begin
      $display("FAIL multi_channel_byte_ring_fifo_core");
    end
    $finish;
  end

endmodule
